### sv/tme_pkg.sv
// ----------------------------------------------------------------------------
// tme_pkg: shared definitions of the Turing machine step engine
// Sizes, request and action codes, item layouts and the tape control bundle.
// ----------------------------------------------------------------------------
package tme_pkg;

  localparam int TAPE_CELLS  = 4096;
  localparam int NUM_STATES  = 64;
  localparam int NUM_SYMBOLS = 8;

  localparam int TAPE_AW    = $clog2(TAPE_CELLS);
  localparam int LEN_W      = TAPE_AW + 1;
  localparam int STATE_W    = 6;
  localparam int SYM_W      = 3;
  localparam int ACT_W      = 2;
  localparam int REQ_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int CNT_W      = 32;
  localparam int RULE_DEPTH = NUM_STATES * NUM_SYMBOLS;
  localparam int RULE_AW    = $clog2(RULE_DEPTH);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LEN_W;
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LENGTH = 2'd2;

  localparam logic [SYM_W-1:0] BLANK = '0;

  typedef enum logic [REQ_W-1:0] {
    REQ_RULE    = 2'd0,
    REQ_CELL    = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_STEP    = 2'd3
  } req_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_RIGHT = 2'd1,
    ACT_LEFT  = 2'd2,
    ACT_HALT  = 2'd3
  } act_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_RUN    = 2'd0,
    ST_NORULE = 2'd1,
    ST_HALT   = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic                 valid;
    act_t                 action;
    logic [SYM_W-1:0]     wsym;
    logic [STATE_W-1:0]   next;
  } rule_t;

  // Request payload, lowest field in the lowest bits.
  typedef struct packed {
    logic [3:0]           pad;
    logic [SYM_W-1:0]     cell_symbol;
    logic [TAPE_AW-1:0]   cell_index;
    logic                 rule_valid;
    logic [STATE_W-1:0]   rule_next_state;
    logic [SYM_W-1:0]     rule_write_symbol;
    logic [ACT_W-1:0]     rule_action;
    logic [SYM_W-1:0]     rule_symbol;
    logic [STATE_W-1:0]   rule_state;
  } in_item_t;

  typedef struct packed {
    logic                 pad;
    logic [STATUS_W-1:0]  run_status;
    logic [CNT_W-1:0]     step_count;
    logic [LEN_W-1:0]     used_length;
    logic [SYM_W-1:0]     symbol_under_head;
    logic [SYM_W-1:0]     symbol_read;
    logic [TAPE_AW-1:0]   head_position;
    logic [STATE_W-1:0]   machine_state;
  } out_item_t;

  localparam int IN_TDATA_W  = $bits(in_item_t);
  localparam int OUT_TDATA_W = $bits(out_item_t);

  // Broadcast to every tape cell. A write lands after the shift, so a blank
  // inserted at cell zero overrides the value shifted in.
  typedef struct packed {
    logic                 adv;
    logic                 ret;
    logic                 wr;
    logic [TAPE_AW-1:0]   idx;
    logic [SYM_W-1:0]     sym;
  } tape_ctl_t;

  function automatic logic [RULE_AW-1:0] rule_key(logic [STATE_W-1:0] st,
                                                  logic [SYM_W-1:0] sy);
    return RULE_AW'(int'(st) * NUM_SYMBOLS + int'(sy));
  endfunction

  function automatic logic key_ok(logic [STATE_W-1:0] st, logic [SYM_W-1:0] sy);
    return (int'(st) < NUM_STATES) && (int'(sy) < NUM_SYMBOLS);
  endfunction

  // (a - b) modulo the tape size, both operands below TAPE_CELLS.
  function automatic logic [TAPE_AW-1:0] mod_sub(logic [TAPE_AW-1:0] a,
                                                 logic [TAPE_AW-1:0] b);
    logic [TAPE_AW:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[TAPE_AW]) begin
      d = d + (TAPE_AW + 1)'(TAPE_CELLS);
    end
    return d[TAPE_AW-1:0];
  endfunction

endpackage

### sv/tme_ram.sv
// ----------------------------------------------------------------------------
// tme_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/tme_cell.sv
// ----------------------------------------------------------------------------
// tme_cell: one tape cell
// Holds one symbol, takes a neighbor's symbol when the ring shifts and
// takes a broadcast symbol when the write index names this cell.
// ----------------------------------------------------------------------------
module tme_cell import tme_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [TAPE_AW-1:0] id,
  input  tape_ctl_t          ctl,
  input  logic [SYM_W-1:0]   right_in,
  input  logic [SYM_W-1:0]   left_in,
  output logic [SYM_W-1:0]   sym
);

  logic [SYM_W-1:0] sym_next;

  always_comb begin
    sym_next = sym;
    if (ctl.adv) begin
      sym_next = right_in;
    end else if (ctl.ret) begin
      sym_next = left_in;
    end
    if (ctl.wr && (ctl.idx == id)) begin
      sym_next = ctl.sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sym <= BLANK;
    end else begin
      sym <= sym_next;
    end
  end

endmodule

### sv/tme_tape.sv
// ----------------------------------------------------------------------------
// tme_tape: circular tape built from a ring of cells
// Cell zero always sits under the head. Advancing moves every symbol one
// cell toward zero, retreating moves it one cell away.
// ----------------------------------------------------------------------------
module tme_tape import tme_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  tape_ctl_t        ctl,
  output logic [SYM_W-1:0] cell0,
  output logic [SYM_W-1:0] cell1,
  output logic [SYM_W-1:0] cell_last
);

  logic [SYM_W-1:0] sym [TAPE_CELLS];

  for (genvar i = 0; i < TAPE_CELLS; i++) begin : g_cell
    tme_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .id       (TAPE_AW'(i)),
      .ctl      (ctl),
      .right_in (sym[(i + 1) % TAPE_CELLS]),
      .left_in  (sym[(i + TAPE_CELLS - 1) % TAPE_CELLS]),
      .sym      (sym[i])
    );
  end

  assign cell0     = sym[0];
  assign cell1     = sym[1];
  assign cell_last = sym[TAPE_CELLS-1];

endmodule

### sv/turing_machine_step_engine.sv
// ----------------------------------------------------------------------------
// turing_machine_step_engine: single-tape Turing machine
// Loads rules and tape cells, restarts the run and executes single steps.
// ----------------------------------------------------------------------------
// Every request gives one result. A rule load, a tape cell load and a step
// are each taken, then commit once the output register is free; a step reads
// the rule memory as it is taken, and the registered read returns before it
// commits. A restart is taken and commits without waiting for the output. The
// tape, a ring of cells, then rotates by ((restart head - physical cell under
// the head) mod TAPE_CELLS) cells, one cell per cycle, where the restart head
// is the start head after clamping to the start length, until the new head
// cell sits at the read position; the result is handed out once the output
// register is free. After reset the rule memory is cleared one entry per cycle,
// with s_tready low; configuration writes are taken throughout. A finished
// result waits in the output register while the next request is taken.
module turing_machine_step_engine import tme_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // rule_state, rule_symbol, rule_action, rule_write_symbol, rule_next_state,
  // rule_valid, cell_index, cell_symbol, zero fill
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // req_type
  input  logic [REQ_W-1:0]       s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // machine_state, head_position, symbol_read, symbol_under_head,
  // used_length, step_count, run_status, zero fill
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_EXEC   = 4'b0100,
    S_ROTATE = 4'b1000
  } fsm_t;

  fsm_t               fsm;
  logic [RULE_AW-1:0] clr_addr;

  logic [STATE_W-1:0] start_state;
  logic [TAPE_AW-1:0] start_head;
  logic [LEN_W-1:0]   start_length;

  logic [STATE_W-1:0] cur_state;
  logic [TAPE_AW-1:0] head;
  logic [TAPE_AW-1:0] head_phys;
  logic [LEN_W-1:0]   len_q;
  logic [CNT_W-1:0]   cnt_q;
  status_t            status_q;
  logic [TAPE_AW-1:0] rot_cnt;

  in_item_t           s_item;
  in_item_t           item_q;
  req_t               req_q;

  logic [SYM_W-1:0]   cell0;
  logic [SYM_W-1:0]   cell1;
  logic [SYM_W-1:0]   cell_last;
  tape_ctl_t          exec_ctl;
  tape_ctl_t          tape_ctl;

  logic [$bits(rule_t)-1:0] rule_raw;
  rule_t              rule_rd;
  rule_t              rule_wr;
  logic               ram_we;
  logic [RULE_AW-1:0] ram_waddr;
  logic               ram_re;

  logic               s_accept;
  logic               out_free;
  logic               exec_fire;
  logic               rot_done;
  logic               emit;

  logic [STATE_W-1:0] state_next;
  logic [TAPE_AW-1:0] head_next;
  logic [TAPE_AW-1:0] head_phys_next;
  logic [LEN_W-1:0]   len_next;
  logic [CNT_W-1:0]   cnt_next;
  status_t            status_next;
  logic [TAPE_AW-1:0] rot_next;
  logic [SYM_W-1:0]   sym_after;
  logic [TAPE_AW-1:0] phys_inc;
  logic [TAPE_AW-1:0] phys_dec;
  logic [LEN_W-1:0]   len_clamp;
  logic [TAPE_AW-1:0] head_clamp;
  logic [TAPE_AW-1:0] load_idx;
  logic               at_right_end;
  logic               tape_full;
  out_item_t          out_next;

  assign s_item    = in_item_t'(s_tdata);
  assign s_tready  = (fsm == S_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign exec_fire = (fsm == S_EXEC) && ((req_q == REQ_RESTART) || out_free);
  assign rot_done  = (fsm == S_ROTATE) && (rot_cnt == '0) && out_free;
  assign emit      = (exec_fire && (req_q != REQ_RESTART)) || rot_done;

  // Rule memory: cleared after reset, written by rule loads.
  assign rule_wr   = '{valid:  item_q.rule_valid,
                       action: act_t'(item_q.rule_action),
                       wsym:   item_q.rule_write_symbol,
                       next:   item_q.rule_next_state};
  assign ram_we    = (fsm == S_CLEAR) ||
                     (exec_fire && (req_q == REQ_RULE) &&
                      key_ok(item_q.rule_state, item_q.rule_symbol));
  assign ram_waddr = (fsm == S_CLEAR) ? clr_addr
                                      : rule_key(item_q.rule_state, item_q.rule_symbol);
  assign ram_re    = s_accept && (req_t'(s_tuser) == REQ_STEP);
  assign rule_rd   = rule_t'(rule_raw);

  tme_ram #(
    .WIDTH ($bits(rule_t)),
    .DEPTH (RULE_DEPTH)
  ) u_rules (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ((fsm == S_CLEAR) ? '0 : rule_wr),
    .re    (ram_re),
    .raddr (rule_key(cur_state, cell0)),
    .rdata (rule_raw)
  );

  assign phys_inc     = (head_phys == TAPE_AW'(TAPE_CELLS - 1)) ? '0
                                                                : head_phys + TAPE_AW'(1);
  assign phys_dec     = (head_phys == '0) ? TAPE_AW'(TAPE_CELLS - 1)
                                          : head_phys - TAPE_AW'(1);
  assign at_right_end = ({1'b0, head} + LEN_W'(1)) >= len_q;
  assign tape_full    = len_q >= LEN_W'(TAPE_CELLS);
  assign load_idx     = mod_sub(item_q.cell_index, head);

  always_comb begin
    len_clamp = start_length;
    if (start_length == '0) begin
      len_clamp = LEN_W'(1);
    end else if (start_length > LEN_W'(TAPE_CELLS)) begin
      len_clamp = LEN_W'(TAPE_CELLS);
    end
    head_clamp = ({1'b0, start_head} < len_clamp) ? start_head
                                                  : TAPE_AW'(len_clamp - LEN_W'(1));
  end

  // Commit values of the request held in item_q.
  always_comb begin
    state_next     = cur_state;
    head_next      = head;
    head_phys_next = head_phys;
    len_next       = len_q;
    cnt_next       = cnt_q;
    status_next    = status_q;
    rot_next       = rot_cnt;
    sym_after      = cell0;
    exec_ctl       = '0;
    case (req_q)
      REQ_RULE: begin
      end
      REQ_CELL: begin
        if (int'(item_q.cell_index) < TAPE_CELLS) begin
          exec_ctl.wr  = 1'b1;
          exec_ctl.idx = load_idx;
          exec_ctl.sym = item_q.cell_symbol;
          if (load_idx == '0) begin
            sym_after = item_q.cell_symbol;
          end
        end
      end
      REQ_RESTART: begin
        state_next     = start_state;
        head_next      = head_clamp;
        head_phys_next = head_clamp;
        len_next       = len_clamp;
        cnt_next       = '0;
        status_next    = ST_RUN;
        rot_next       = mod_sub(head_clamp, head_phys);
      end
      REQ_STEP: begin
        if (status_q == ST_RUN) begin
          cnt_next = cnt_q + CNT_W'(1);
          if (!key_ok(cur_state, cell0) || !rule_rd.valid) begin
            status_next = ST_NORULE;
          end else begin
            case (rule_rd.action)
              ACT_WRITE: begin
                exec_ctl.wr  = 1'b1;
                exec_ctl.idx = '0;
                exec_ctl.sym = rule_rd.wsym;
                state_next   = rule_rd.next;
                sym_after    = rule_rd.wsym;
              end
              ACT_RIGHT: begin
                if (at_right_end && tape_full) begin
                  status_next = ST_FULL;
                end else begin
                  exec_ctl.adv   = 1'b1;
                  head_next      = head + TAPE_AW'(1);
                  head_phys_next = phys_inc;
                  state_next     = rule_rd.next;
                  sym_after      = cell1;
                  if (at_right_end) begin
                    // Append a blank cell at the right end of the tape.
                    exec_ctl.wr  = 1'b1;
                    exec_ctl.idx = '0;
                    exec_ctl.sym = BLANK;
                    len_next     = len_q + LEN_W'(1);
                    sym_after    = BLANK;
                  end
                end
              end
              ACT_LEFT: begin
                if ((head == '0) && tape_full) begin
                  status_next = ST_FULL;
                end else begin
                  exec_ctl.ret   = 1'b1;
                  head_phys_next = phys_dec;
                  state_next     = rule_rd.next;
                  sym_after      = cell_last;
                  if (head == '0) begin
                    // The origin steps back one cell, which becomes a blank.
                    exec_ctl.wr  = 1'b1;
                    exec_ctl.idx = '0;
                    exec_ctl.sym = BLANK;
                    len_next     = len_q + LEN_W'(1);
                    sym_after    = BLANK;
                  end else begin
                    head_next = head - TAPE_AW'(1);
                  end
                end
              end
              default: begin
                status_next = ST_HALT;
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    tape_ctl = '0;
    if (exec_fire) begin
      tape_ctl = exec_ctl;
    end else if ((fsm == S_ROTATE) && (rot_cnt != '0)) begin
      tape_ctl.adv = 1'b1;
    end
  end

  tme_tape u_tape (
    .clk       (clk),
    .rst       (rst),
    .ctl       (tape_ctl),
    .cell0     (cell0),
    .cell1     (cell1),
    .cell_last (cell_last)
  );

  always_comb begin
    out_next     = '0;
    if (fsm == S_ROTATE) begin
      out_next.machine_state     = cur_state;
      out_next.head_position     = head;
      out_next.symbol_read       = cell0;
      out_next.symbol_under_head = cell0;
      out_next.used_length       = len_q;
      out_next.step_count        = cnt_q;
      out_next.run_status        = status_q;
    end else begin
      out_next.machine_state     = state_next;
      out_next.head_position     = head_next;
      out_next.symbol_read       = (req_q == REQ_STEP) ? cell0 : sym_after;
      out_next.symbol_under_head = sym_after;
      out_next.used_length       = len_next;
      out_next.step_count        = cnt_next;
      out_next.run_status        = status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_state  <= '0;
      start_head   <= '0;
      start_length <= LEN_W'(1);
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_START_STATE:  start_state  <= cfg_data[STATE_W-1:0];
        CFG_START_HEAD:   start_head   <= cfg_data[TAPE_AW-1:0];
        CFG_START_LENGTH: start_length <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_CLEAR;
      clr_addr  <= '0;
      cur_state <= '0;
      head      <= '0;
      head_phys <= '0;
      len_q     <= LEN_W'(1);
      cnt_q     <= '0;
      status_q  <= ST_RUN;
      rot_cnt   <= '0;
      req_q     <= REQ_RULE;
      m_tvalid  <= 1'b0;
    end else begin
      case (fsm)
        S_CLEAR: begin
          clr_addr <= clr_addr + RULE_AW'(1);
          if (clr_addr == RULE_AW'(RULE_DEPTH - 1)) begin
            fsm <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_accept) begin
            req_q <= req_t'(s_tuser);
            fsm   <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            fsm <= (req_q == REQ_RESTART) ? S_ROTATE : S_IDLE;
          end
        end
        S_ROTATE: begin
          if (rot_cnt != '0) begin
            rot_cnt <= rot_cnt - TAPE_AW'(1);
          end else if (out_free) begin
            fsm <= S_IDLE;
          end
        end
        default: begin
          fsm <= S_IDLE;
        end
      endcase

      if (exec_fire) begin
        cur_state <= state_next;
        head      <= head_next;
        head_phys <= head_phys_next;
        len_q     <= len_next;
        cnt_q     <= cnt_next;
        status_q  <= status_next;
        rot_cnt   <= rot_next;
      end

      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      item_q <= s_item;
    end
    if (emit) begin
      m_tdata <= out_next;
    end
  end

  // The head never leaves the used part of the tape.
  a_head_in_tape: assert property (@(posedge clk) disable iff (rst)
    {1'b0, head} < len_q)
    else $error("head position outside the used tape");

  // A stopped machine stays stopped until a restart commits.
  a_stop_sticks: assert property (@(posedge clk) disable iff (rst)
    (status_q != ST_RUN) && !(exec_fire && (req_q == REQ_RESTART))
    |=> status_q == $past(status_q))
    else $error("run status changed without a restart");

  // The step counter only moves when a step or a restart commits.
  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    !(exec_fire && ((req_q == REQ_STEP) || (req_q == REQ_RESTART)))
    |=> $stable(cnt_q))
    else $error("step counter moved outside a step");

  // The ring rotates only after a restart has committed.
  a_rotate_entry: assert property (@(posedge clk) disable iff (rst)
    (fsm == S_ROTATE) && ($past(fsm) != S_ROTATE)
    |-> $past(exec_fire) && ($past(req_q) == REQ_RESTART))
    else $error("tape rotation entered without a restart");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the Turing machine step engine
// Sends rule loads, tape cell loads, restarts and steps through the request
// stream with random gaps and output stalls. A scoreboard mirrors the tape,
// the rules and the machine registers. It checks every result field by field
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb import tme_pkg::*; ();

  // Index 3 has no register behind it, so a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_ITEMS   = 260;
  localparam int RANDOM_PHASES = 7;

  class machine_scoreboard_t;
    rule_t              rules[RULE_DEPTH];
    logic [SYM_W-1:0]   tape[TAPE_CELLS];
    logic [TAPE_AW-1:0] origin;
    logic [TAPE_AW-1:0] head;
    logic [LEN_W-1:0]   length;
    logic [STATE_W-1:0] state;
    logic [CNT_W-1:0]   steps;
    status_t            status;
    logic [STATE_W-1:0] start_state;
    logic [TAPE_AW-1:0] start_head;
    logic [LEN_W-1:0]   start_length;
    out_item_t          expected_results[$];
    int                 errors;

    function new();
      foreach (rules[i]) rules[i] = '0;
      foreach (tape[i]) tape[i] = BLANK;
      origin       = '0;
      head         = '0;
      length       = LEN_W'(1);
      state        = '0;
      steps        = '0;
      status       = ST_RUN;
      start_state  = '0;
      start_head   = '0;
      start_length = LEN_W'(1);
      errors       = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_START_STATE:  start_state = value[STATE_W-1:0];
        CFG_START_HEAD:   start_head = value[TAPE_AW-1:0];
        CFG_START_LENGTH: start_length = value;
        default: ;
      endcase
    endfunction

    // The tape size is a power of two, so the ring wraps by truncation.
    function logic [TAPE_AW-1:0] cell_addr(logic [TAPE_AW-1:0] logical);
      return origin + logical;
    endfunction

    function void take_step();
      logic [SYM_W-1:0] sym;
      rule_t            r;
      if (status != ST_RUN) return;
      steps = steps + CNT_W'(1);
      sym = tape[cell_addr(head)];
      r = rules[{state, sym}];
      if (!r.valid) begin
        status = ST_NORULE;
        return;
      end
      case (r.action)
        ACT_WRITE: begin
          tape[cell_addr(head)] = r.wsym;
          state = r.next;
        end
        ACT_RIGHT: begin
          if (int'(head) + 1 >= int'(length)) begin
            if (int'(length) >= TAPE_CELLS) begin
              status = ST_FULL;
              return;
            end
            tape[cell_addr(length[TAPE_AW-1:0])] = BLANK;
            length = length + LEN_W'(1);
          end
          head = head + TAPE_AW'(1);
          state = r.next;
        end
        ACT_LEFT: begin
          if (head == '0) begin
            if (int'(length) >= TAPE_CELLS) begin
              status = ST_FULL;
              return;
            end
            // Growing at the left end moves the origin back by one cell.
            origin = origin - TAPE_AW'(1);
            tape[origin] = BLANK;
            length = length + LEN_W'(1);
          end else begin
            head = head - TAPE_AW'(1);
          end
          state = r.next;
        end
        default: status = ST_HALT;
      endcase
    endfunction

    function void note_request(req_t kind, in_item_t item);
      out_item_t        snap;
      logic [SYM_W-1:0] read_sym;
      int               len;
      read_sym = tape[cell_addr(head)];
      case (kind)
        REQ_RULE: begin
          rules[{item.rule_state, item.rule_symbol}] = '{
            valid:  item.rule_valid,
            action: act_t'(item.rule_action),
            wsym:   item.rule_write_symbol,
            next:   item.rule_next_state
          };
        end
        REQ_CELL: tape[cell_addr(item.cell_index)] = item.cell_symbol;
        REQ_RESTART: begin
          len = int'(start_length);
          if (len == 0) len = 1;
          if (len > TAPE_CELLS) len = TAPE_CELLS;
          origin = '0;
          length = LEN_W'(len);
          head   = (int'(start_head) < len) ? start_head : TAPE_AW'(len - 1);
          state  = start_state;
          steps  = '0;
          status = ST_RUN;
        end
        REQ_STEP: take_step();
        default: ;
      endcase
      if (kind != REQ_STEP) read_sym = tape[cell_addr(head)];
      snap = '0;
      snap.machine_state     = state;
      snap.head_position     = head;
      snap.symbol_read       = read_sym;
      snap.symbol_under_head = tape[cell_addr(head)];
      snap.used_length       = length;
      snap.step_count        = steps;
      snap.run_status        = status;
      expected_results.push_back(snap);
    endfunction

    function void compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t due;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
        return;
      end
      due = expected_results.pop_front();
      compare_field("machine_state", CNT_W'(due.machine_state), CNT_W'(got.machine_state));
      compare_field("head_position", CNT_W'(due.head_position), CNT_W'(got.head_position));
      compare_field("symbol_read", CNT_W'(due.symbol_read), CNT_W'(got.symbol_read));
      compare_field("symbol_under_head", CNT_W'(due.symbol_under_head),
                    CNT_W'(got.symbol_under_head));
      compare_field("used_length", CNT_W'(due.used_length), CNT_W'(got.used_length));
      compare_field("step_count", due.step_count, got.step_count);
      compare_field("run_status", CNT_W'(due.run_status), CNT_W'(got.run_status));
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_wen;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [REQ_W-1:0]       s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  machine_scoreboard_t book = new();
  bit gaps_on;
  bit stalls_on;
  bit hold_asked;

  turing_machine_step_engine dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Inputs change only at rising edges, so the values seen at the falling edge
  // are the ones the next rising edge takes.
  initial begin : result_monitor
    forever begin
      @(negedge clk);
      if (rst === 1'b0 && m_tvalid === 1'b1 && m_tready === 1'b1) book.check_result(m_tdata);
    end
  end

  initial begin : result_sink
    int stall_left;
    int hold_left;
    bit hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic in_item_t noise_item();
    logic [63:0] raw;
    in_item_t    item;
    raw = {$urandom(), $urandom()};
    item = raw[IN_TDATA_W-1:0];
    item.pad = '0;
    return item;
  endfunction

  task automatic send_request(req_t kind, in_item_t item);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= item;
    do @(negedge clk); while (s_tready !== 1'b1);
    book.note_request(kind, item);
    @(posedge clk);
  endtask

  task automatic send_plain(req_t kind);
    send_request(kind, noise_item());
  endtask

  task automatic load_rule(logic [STATE_W-1:0] st, logic [SYM_W-1:0] sy, act_t act,
                           logic [SYM_W-1:0] wsym, logic [STATE_W-1:0] nxt, logic valid);
    in_item_t item;
    item = noise_item();
    item.rule_state        = st;
    item.rule_symbol       = sy;
    item.rule_action       = act;
    item.rule_write_symbol = wsym;
    item.rule_next_state   = nxt;
    item.rule_valid        = valid;
    send_request(REQ_RULE, item);
  endtask

  task automatic load_cell(logic [TAPE_AW-1:0] idx, logic [SYM_W-1:0] sym);
    in_item_t item;
    item = noise_item();
    item.cell_index  = idx;
    item.cell_symbol = sym;
    send_request(REQ_CELL, item);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    book.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [STATE_W-1:0] st, logic [TAPE_AW-1:0] hd,
                                logic [LEN_W-1:0] len);
    write_register(CFG_START_STATE, CFG_DATA_W'(st));
    write_register(CFG_START_HEAD, CFG_DATA_W'(hd));
    write_register(CFG_START_LENGTH, len);
    cfg_wen <= 1'b0;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (book.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Loads a small random program over a few states, seeds some cells and then
  // mostly steps, with stray loads and restarts mixed in.
  task automatic run_phase(int items, bit hold, bit pause);
    logic [STATE_W-1:0] states[6];
    int                 kinds;
    int                 pick;
    int                 sent;
    act_t               act;
    kinds = $urandom_range(2, 6);
    states[0] = book.start_state;
    for (int i = 1; i < kinds; i++) states[i] = STATE_W'($urandom_range(0, NUM_STATES - 1));
    sent = 0;
    for (int s = 0; s < kinds; s++) begin
      for (int sy = 0; sy < NUM_SYMBOLS; sy++) begin
        pick = $urandom_range(0, 99);
        if (pick < 38) act = ACT_WRITE;
        else if (pick < 68) act = ACT_RIGHT;
        else if (pick < 98) act = ACT_LEFT;
        else act = ACT_HALT;
        load_rule(states[s], SYM_W'(sy), act, SYM_W'($urandom_range(0, 7)),
                  states[$urandom_range(0, kinds - 1)], $urandom_range(0, 39) != 0);
        sent++;
      end
    end
    repeat ($urandom_range(0, 6)) begin
      load_cell(TAPE_AW'($urandom_range(0, 15)), SYM_W'($urandom_range(0, 7)));
      sent++;
    end
    send_plain(REQ_RESTART);
    sent++;
    while (sent < items) begin
      if (sent == items / 2) begin
        if (hold) hold_asked = 1'b1;
        if (pause) wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (book.status != ST_RUN && $urandom_range(0, 3) == 0) begin
        send_plain(REQ_RESTART);
      end else if (pick < 88) begin
        send_plain(REQ_STEP);
      end else if (pick < 93) begin
        send_plain(REQ_RULE);
      end else if (pick < 98) begin
        load_cell($urandom_range(0, 1) ? TAPE_AW'($urandom()) : TAPE_AW'($urandom_range(0, 31)),
                  SYM_W'($urandom()));
      end else begin
        send_plain(REQ_RESTART);
      end
      sent++;
    end
  endtask

  initial begin : stimulus
    rst        <= 1'b1;
    cfg_wen    <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    s_tvalid   <= 1'b0;
    s_tuser    <= '0;
    s_tdata    <= '0;
    gaps_on    = 1'b1;
    stalls_on  = 1'b1;
    hold_asked = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    apply_settings('0, '0, LEN_W'(1));

    // Empty rule table: the first step stops the machine, the next one is idle.
    send_plain(REQ_STEP);
    send_plain(REQ_STEP);
    load_rule(0, 0, ACT_WRITE, 5, 1, 1'b1);
    load_rule(1, 5, ACT_RIGHT, 0, 2, 1'b1);
    load_rule(2, 0, ACT_LEFT, 0, 3, 1'b1);
    load_rule(3, 5, ACT_LEFT, 0, 4, 1'b1);
    load_rule(4, 0, ACT_HALT, 6, 9, 1'b1);
    load_cell(TAPE_AW'(TAPE_CELLS - 1), 7);
    send_plain(REQ_RESTART);
    // Write, append at the right end, move back, insert at the left end,
    // halt, and one step while halted.
    repeat (6) send_plain(REQ_STEP);
    load_rule(4, 0, ACT_WRITE, 1, 1, 1'b0);
    load_cell(0, 3);
    send_plain(REQ_RESTART);
    send_plain(REQ_STEP);

    // Whole tape in use, head on the last cell: a right move finds the tape full.
    wait_drained();
    write_register(CFG_START_STATE, CFG_DATA_W'(NUM_STATES - 1));
    write_register(CFG_START_HEAD, CFG_DATA_W'(TAPE_CELLS - 1));
    write_register(CFG_START_LENGTH, '1);
    write_register(CFG_SPARE, CFG_DATA_W'(5));
    cfg_wen <= 1'b0;
    load_rule(63, 3, ACT_RIGHT, 1, 62, 1'b1);
    send_plain(REQ_RESTART);
    send_plain(REQ_STEP);

    // Whole tape in use, head on the first cell: a left move finds it full.
    wait_drained();
    apply_settings(62, 0, LEN_W'(TAPE_CELLS));
    load_rule(62, 5, ACT_LEFT, 2, 62, 1'b1);
    send_plain(REQ_RESTART);
    send_plain(REQ_STEP);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      case (p)
        0: apply_settings(STATE_W'($urandom()), TAPE_AW'($urandom_range(0, 3)),
                          LEN_W'($urandom_range(1, 8)));
        // A zero length counts as one cell and the head saturates onto it.
        1: apply_settings(STATE_W'($urandom()), TAPE_AW'(TAPE_CELLS - 1), '0);
        2: apply_settings(STATE_W'(NUM_STATES - 1), TAPE_AW'($urandom_range(0, 15)),
                          LEN_W'(16));
        3: apply_settings('0, TAPE_AW'(TAPE_CELLS - 1), '1);
        default: apply_settings(STATE_W'($urandom()), TAPE_AW'($urandom_range(0, 15)),
                                LEN_W'($urandom_range(1, 64)));
      endcase
      gaps_on   = (p != 4) && (p != RANDOM_PHASES - 1);
      stalls_on = gaps_on;
      run_phase(PHASE_ITEMS, p == 1, p == 2);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (book.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### turing_machine_step_engine.f
sv/tme_pkg.sv
sv/tme_ram.sv
sv/tme_cell.sv
sv/tme_tape.sv
sv/turing_machine_step_engine.sv
tb/tb.sv
